// ===== sv/lgs_pkg.sv =====
// Shared types and constants of the linear gradient span shader.
package lgs_pkg;
  localparam int unsigned MaxStopsDefault = 16;
  localparam int unsigned MaxSpanDefault  = 64;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdSpan = 1'b1;

  localparam logic [2:0] RegCoefX   = 3'd0;
  localparam logic [2:0] RegCoefY   = 3'd1;
  localparam logic [2:0] RegOffset  = 3'd2;
  localparam logic [2:0] RegTile    = 3'd3;
  localparam logic [2:0] RegStopCnt = 3'd4;

  localparam logic [1:0] TileClamp  = 2'd0;
  localparam logic [1:0] TileRepeat = 2'd1;
  localparam logic [1:0] TileMirror = 2'd2;

  typedef struct packed {
    logic        command;
    logic [3:0]  stop_index;
    logic [31:0] stop_color;
    logic [11:0] start_x;
    logic [11:0] row_y;
    logic [6:0]  span_length;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // Rounded division of a 16-bit product by 255 via reciprocal multiply.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] w;
    logic [25:0] q;
    begin
      w = {1'b0, v} + 17'd127;
      q = (26'(w) * 26'd257 + 26'd257) >> 16;
      div255 = q[7:0];
    end
  endfunction
endpackage

// ===== sv/lgs_if.sv =====
// Valid/ready channel interface carrying a typed payload.
interface lgs_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/lgs_pos.sv =====
// Span sequencer: computes the start position and steps it per pixel.
module lgs_pos #(
  parameter int unsigned MAX_SPAN = lgs_pkg::MaxSpanDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [11:0]        start_x,
  input  logic [11:0]        row_y,
  input  logic [6:0]         span_length,
  input  logic signed [31:0] coef_x,
  input  logic signed [31:0] coef_y,
  input  logic signed [31:0] coef_offset,
  input  logic               advance,
  output logic               busy,
  output logic               pix_valid,
  output logic signed [47:0] pos,
  output logic               pix_last
);
  localparam int unsigned CW = $clog2(MAX_SPAN + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_MULX, ST_SUM, ST_RUN} state_t;

  state_t state_r;
  logic signed [47:0] px_r, py_r, pos_r;
  logic [CW-1:0] left_r;
  logic [CW-1:0] len_sat;
  logic signed [48:0] sum;

  always_comb begin
    if (span_length > 7'(MAX_SPAN > 127 ? 127 : MAX_SPAN)) len_sat = CW'(MAX_SPAN);
    else len_sat = CW'(span_length);
    sum = 49'(px_r) + 49'(py_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      left_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (start) begin
          left_r  <= len_sat;
          px_r    <= 48'(coef_x) * 48'($signed({1'b0, start_x, 1'b1}));
          py_r    <= 48'(coef_y) * 48'($signed({1'b0, row_y, 1'b1}));
          state_r <= (len_sat == '0) ? ST_IDLE : ST_MULX;
        end
        ST_MULX: state_r <= ST_SUM;
        ST_SUM: begin
          pos_r   <= 48'(sum >>> 1) + 48'(coef_offset);
          state_r <= ST_RUN;
        end
        ST_RUN: if (advance) begin
          pos_r  <= pos_r + 48'(coef_x);
          left_r <= left_r - CW'(1);
          if (left_r == CW'(1)) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign pix_valid = (state_r == ST_RUN);
  assign pos       = pos_r;
  assign pix_last  = (left_r == CW'(1));
endmodule

// ===== sv/lgs_shade.sv =====
// Tiling, stop table memory, interpolation and premultiply pipeline.
module lgs_shade #(
  parameter int unsigned MAX_STOPS = lgs_pkg::MaxStopsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [3:0]         wr_index,
  input  logic [31:0]        wr_color,
  input  logic [1:0]         tile_mode,
  input  logic [4:0]         stop_count,
  input  logic               in_valid,
  input  logic signed [47:0] pos,
  input  logic               in_last,
  input  logic               stall,
  output logic               busy,
  output logic               res_valid,
  output logic [31:0]        res_pixel,
  output logic               res_last
);
  localparam int unsigned IW = $clog2(MAX_STOPS);
  localparam int unsigned NW = IW + 1;
  localparam logic [1:0] TILE_REP = lgs_pkg::TileRepeat;
  localparam logic [1:0] TILE_MIR = lgs_pkg::TileMirror;

  logic [31:0] mem0 [MAX_STOPS];
  logic [31:0] mem1 [MAX_STOPS];

  logic [NW-1:0] n_eff;
  logic [16:0]   t;
  logic [16:0]   u;
  always_comb begin
    if (stop_count == 5'd0) n_eff = NW'(1);
    else if (32'(stop_count) > MAX_STOPS) n_eff = NW'(MAX_STOPS);
    else n_eff = NW'(stop_count);
    u = pos[16:0];
    case (tile_mode)
      TILE_REP: t = {1'b0, pos[15:0]};
      TILE_MIR: t = (u <= 17'd65536) ? u : 17'(18'd131072 - 18'(u));
      default: begin
        if (pos < 0) t = '0;
        else if (pos > 48'sd65536) t = 17'd65536;
        else t = pos[16:0];
      end
    endcase
  end

  // Stage 1: scale by stop count minus one.
  logic v1_r, l1_r;
  logic [NW+16:0] s1_r;
  logic [NW-1:0] nm1_r;
  // Stage 2: memory read.
  logic v2_r, l2_r, end2_r;
  logic [15:0] f2_r;
  logic [31:0] c0_r, c1_r;
  // Stage 3: interpolation.
  logic v3_r, l3_r;
  logic [7:0] ch3_r [4];
  // Stage 4: premultiply products.
  logic v4_r, l4_r;
  logic [7:0]  a4_r;
  logic [15:0] pm4_r [3];

  logic [IW-1:0] idx, idx1, idxl;
  logic          is_end;
  always_comb begin
    is_end = (s1_r[NW+16:16] >= (NW+1)'(nm1_r));
    idx    = s1_r[IW+15:16];
    idx1   = IW'(idx + IW'(1));
    idxl   = IW'(nm1_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_index) < MAX_STOPS)) begin
      mem0[IW'(wr_index)] <= wr_color;
      mem1[IW'(wr_index)] <= wr_color;
    end
    if (!stall) begin
      c0_r <= mem0[is_end ? idxl : idx];
      c1_r <= mem1[is_end ? idxl : idx1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (!stall) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      l1_r  <= in_last;
      s1_r  <= (NW+17)'(t) * (NW+17)'(n_eff - NW'(1));
      nm1_r <= n_eff - NW'(1);
      l2_r  <= l1_r;
      end2_r <= is_end;
      f2_r  <= s1_r[15:0];
      l3_r  <= l2_r;
      for (int k = 0; k < 4; k++) begin
        ch3_r[k] <= end2_r ? c0_r[8*k +: 8] :
          8'((25'(c0_r[8*k +: 8]) * (25'd65536 - 25'(f2_r)) +
              25'(c1_r[8*k +: 8]) * 25'(f2_r) + 25'd32768) >> 16);
      end
      l4_r <= l3_r;
      a4_r <= ch3_r[3];
      for (int k = 0; k < 3; k++) pm4_r[k] <= 16'(ch3_r[k]) * 16'(ch3_r[3]);
    end
  end

  assign res_valid = v4_r;
  assign res_last  = l4_r;
  assign res_pixel = {a4_r, lgs_pkg::div255(pm4_r[2]), lgs_pkg::div255(pm4_r[1]),
                      lgs_pkg::div255(pm4_r[0])};
  assign busy = v1_r | v2_r | v3_r | v4_r;
endmodule

// ===== sv/linear_gradient_span_shader.sv =====
// A span beat is accepted only while the stepper and the shade pipeline are idle.
// Throughput: one pixel per cycle from the position stepper while the output
// is not stalled; a load beat writes one stop table entry if its index is in range.
// The stop table is a two-copy memory read once per pixel into registers.
// Reset (rst_n low, synchronous) restores register defaults and empties the
// pipeline; stop table contents stay undefined until loaded.
module linear_gradient_span_shader #(
  parameter int unsigned MAX_STOPS = lgs_pkg::MaxStopsDefault,
  parameter int unsigned MAX_SPAN  = lgs_pkg::MaxSpanDefault
) (
  input  logic clk,
  input  logic rst_n,
  lgs_if.sink   in_ch,
  lgs_if.source out_ch,
  lgs_if.sink   cfg_ch
);
  lgs_pkg::in_item_t  in_d;
  lgs_pkg::cfg_item_t cfg_d;
  logic signed [31:0] coef_x_r, coef_y_r, coef_off_r;
  logic [1:0] tile_r;
  logic [4:0] cnt_r;

  logic pos_busy, pix_valid, pix_last, sh_busy, res_valid, res_last, stall;
  logic signed [47:0] pos;
  logic [31:0] res_pixel;
  logic out_v_r, out_l_r;
  logic [31:0] out_p_r;
  logic in_acc;

  assign in_d  = in_ch.data;
  assign cfg_d = cfg_ch.data;
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !(pos_busy || sh_busy);
  assign in_acc = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_x_r <= 32'sd65536; coef_y_r <= '0; coef_off_r <= '0;
      tile_r <= lgs_pkg::TileClamp; cnt_r <= 5'd2;
    end else if (cfg_ch.valid) begin
      unique case (cfg_d.index)
        lgs_pkg::RegCoefX:   coef_x_r   <= cfg_d.data;
        lgs_pkg::RegCoefY:   coef_y_r   <= cfg_d.data;
        lgs_pkg::RegOffset:  coef_off_r <= cfg_d.data;
        lgs_pkg::RegTile:    tile_r     <= cfg_d.data[1:0];
        lgs_pkg::RegStopCnt: cnt_r      <= cfg_d.data[4:0];
        default: ;
      endcase
    end
  end

  // The output register stalls the whole pipeline while its beat is held.
  assign stall = out_v_r && !out_ch.ready;

  lgs_pos #(.MAX_SPAN(MAX_SPAN)) u_pos (
    .clk, .rst_n,
    .start(in_acc && in_d.command == lgs_pkg::CmdSpan),
    .start_x(in_d.start_x), .row_y(in_d.row_y), .span_length(in_d.span_length),
    .coef_x(coef_x_r), .coef_y(coef_y_r), .coef_offset(coef_off_r),
    .advance(!stall), .busy(pos_busy), .pix_valid(pix_valid), .pos(pos),
    .pix_last(pix_last)
  );

  lgs_shade #(.MAX_STOPS(MAX_STOPS)) u_shade (
    .clk, .rst_n,
    .wr_en(in_acc && in_d.command == lgs_pkg::CmdLoad),
    .wr_index(in_d.stop_index), .wr_color(in_d.stop_color),
    .tile_mode(tile_r), .stop_count(cnt_r),
    .in_valid(pix_valid), .pos(pos), .in_last(pix_last), .stall(stall),
    .busy(sh_busy), .res_valid(res_valid), .res_pixel(res_pixel), .res_last(res_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!stall) begin
      out_v_r <= res_valid;
      out_p_r <= res_pixel;
      out_l_r <= res_last;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = '{pixel: out_p_r, last_pixel: out_l_r};
endmodule
